// ===== rtl/strongly_connected_components_macros.svh =====
// ------------------------------------------------------------------------
// SCC assertion macros
// Immediate-implication and next-cycle-implication checks with reset gate.
// ------------------------------------------------------------------------
`ifndef STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH

// same-cycle implication
`define SCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scc_pkg.sv =====
// ------------------------------------------------------------------------
// SCC package
// Shared constants, codes and types of the strongly connected components block.
// ------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int VID_W            = 6;
    localparam int CMD_W            = 2;
    localparam int VCOUNT_W         = 7;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
    localparam logic [PADDR_W-1:0]  ADDR_VCOUNT  = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_RUN   = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_WR,
        S_P1_ROOT,
        S_WALK_START,
        S_READ_ROW,
        S_SCAN,
        S_PICK,
        S_POP_WAIT,
        S_P2_POP,
        S_P2_WAIT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [VID_W-1:0] vertex_id;
        logic             component_end;
        logic             last;
        logic             empty_res;
    } t_result;

    typedef struct packed {
        logic             found;
        logic [VID_W-1:0] idx;
    } t_scan;

endpackage

`default_nettype wire

// ===== rtl/scc_if.sv =====
// ------------------------------------------------------------------------
// SCC channel interfaces
// Valid/ready channels for command items and component results.
// ------------------------------------------------------------------------
`default_nettype none

interface scc_in_if;
    logic                       valid;
    logic                       ready;
    logic [scc_pkg::CMD_W-1:0]  cmd;
    logic [scc_pkg::VID_W-1:0]  src_vertex;
    logic [scc_pkg::VID_W-1:0]  dst_vertex;

    modport source (output valid, cmd, src_vertex, dst_vertex, input ready);
    modport sink   (input valid, cmd, src_vertex, dst_vertex, output ready);
endinterface

interface scc_out_if;
    logic                       valid;
    logic                       ready;
    logic [scc_pkg::VID_W-1:0]  vertex_id;
    logic                       component_end;
    logic                       last;
    logic                       empty_res;

    modport source (output valid, vertex_id, component_end, last, empty_res, input ready);
    modport sink   (input valid, vertex_id, component_end, last, empty_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/scc_ram.sv =====
// ------------------------------------------------------------------------
// SCC generic RAM
// One write port, one read port with registered read data.
// ------------------------------------------------------------------------
`default_nettype none

module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/scc_scan.sv =====
// ------------------------------------------------------------------------
// SCC neighbor scan unit
// Registers the open-neighbor set of a row, then finds its lowest member.
// ------------------------------------------------------------------------
`default_nettype none

module scc_scan #(
    parameter int N = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [N-1:0]             i_row,
    input  wire logic [N-1:0]             i_allowed,
    input  wire logic [$clog2(N+1)-1:0]   i_k,
    output scc_pkg::t_scan                o_res
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0] r_cand;
    logic [N-1:0] w_cand;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_cand[i] = i_row[i] & i_allowed[i] & (CW'(i) >= i_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cand <= w_cand;
        end
    end

    always_comb begin
        o_res.found = |r_cand;
        o_res.idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_cand[i]) begin
                o_res.idx = scc_pkg::VID_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/strongly_connected_components.sv =====
// ------------------------------------------------------------------------
// Strongly connected components
// Two-pass depth-first SCC engine over forward and reverse adjacency bit matrices.
// ------------------------------------------------------------------------
// Usage:
//   i_in carries commands: clear graph, add edge, run. A clear empties
//   the graph, an add edge reads both rows and writes them back, and an
//   add edge out of range is ignored. A run walks the graph twice by
//   depth-first search; a row scan runs row read, neighbor scan and
//   decision, finding the lowest open neighbor at once; a pop restores
//   the parent from the search stack, and each root candidate and
//   finish entry is checked in turn. The row memory read and the shared
//   scan unit set the run's length, whatever the edge count, plus output
//   stalls. The block is not ready while a command is in progress. o_out
//   gives one transfer per vertex, grouped by component, with
//   component_end and last flags; a run on zero vertices gives one
//   transfer with empty_res set. One result waits in a pending register
//   and one in the output register; when o_out stalls, the second-pass
//   walk holds. The user must write vertex_count (byte address 0) over
//   the APB port only while idle; the block does not enforce it. Reset
//   empties the graph, sets vertex_count to 64 and drops results.
// ------------------------------------------------------------------------
`default_nettype none
`include "strongly_connected_components_macros.svh"

module strongly_connected_components #(
    parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    scc_in_if.sink                             i_in,
    scc_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [scc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [scc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [scc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = VW + CW;

    scc_pkg::t_state  r_state, n_state;
    logic [scc_pkg::VCOUNT_W-1:0] r_vcount;
    logic [MAX_VERTICES-1:0] r_fval, n_fval;
    logic [MAX_VERTICES-1:0] r_rval, n_rval;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [VW-1:0] r_src, n_src;
    logic [VW-1:0] r_dst, n_dst;
    logic          r_pass, n_pass;
    logic [CW-1:0] r_root_cnt, n_root_cnt;
    logic [VW-1:0] r_root_v, n_root_v;
    logic [VW-1:0] r_top_v, n_top_v;
    logic [CW-1:0] r_top_k, n_top_k;
    logic [CW-1:0] r_depth, n_depth;
    logic [CW-1:0] r_fc, n_fc;
    scc_pkg::t_result r_pend, n_pend;
    logic             r_pend_valid, n_pend_valid;
    scc_pkg::t_result r_out;
    logic             r_out_valid;

    logic [CW-1:0]           w_n;
    logic [MAX_VERTICES-1:0] w_valid;
    logic                    w_accept;
    logic                    w_can_push;
    logic                    w_move;
    logic                    w_edge_ok;

    logic [MAX_VERTICES-1:0] w_fwd_rd, w_rev_rd;
    logic [MAX_VERTICES-1:0] w_fwd_wd, w_rev_wd;
    logic [VW-1:0]           w_fwd_ra, w_rev_ra;
    logic                    w_mat_we;
    logic [MAX_VERTICES-1:0] w_row;
    logic                    w_scan_en;
    scc_pkg::t_scan          w_scan;

    logic          w_ss_we;
    logic [VW-1:0] w_ss_wa, w_ss_ra;
    logic [SW-1:0] w_ss_wd, w_ss_rd;
    logic          w_fs_we;
    logic [VW-1:0] w_fs_wa, w_fs_ra;
    logic [VW-1:0] w_fs_rd;

    // vertex count clamped to capacity
    assign w_n = (r_vcount > scc_pkg::VCOUNT_W'(MAX_VERTICES))
        ? CW'(MAX_VERTICES) : CW'(r_vcount);

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_valid[i] = (CW'(i) < w_n);
        end
    end

    assign i_in.ready  = (r_state == scc_pkg::S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_can_push  = !r_out_valid || o_out.ready;
    assign w_edge_ok   = ({1'b0, i_in.src_vertex} < scc_pkg::VCOUNT_W'(w_n))
                      && ({1'b0, i_in.dst_vertex} < scc_pkg::VCOUNT_W'(w_n));

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr == scc_pkg::ADDR_VCOUNT)
        ? scc_pkg::PDATA_W'(r_vcount) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= scc_pkg::VCOUNT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == scc_pkg::ADDR_VCOUNT) begin
            r_vcount <= pwdata[scc_pkg::VCOUNT_W-1:0];
        end
    end

    // adjacency memories
    assign w_fwd_ra = (r_state == scc_pkg::S_IDLE) ? VW'(i_in.src_vertex) : r_top_v;
    assign w_rev_ra = (r_state == scc_pkg::S_IDLE) ? VW'(i_in.dst_vertex) : r_top_v;
    assign w_mat_we = (r_state == scc_pkg::S_EDGE_WR);

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_fwd_wd[i] = (w_fwd_rd[i] & r_fval[r_src]) | (VW'(i) == r_dst);
            w_rev_wd[i] = (w_rev_rd[i] & r_rval[r_dst]) | (VW'(i) == r_src);
        end
    end

    scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (w_mat_we),
        .i_waddr (r_src),
        .i_wdata (w_fwd_wd),
        .i_raddr (w_fwd_ra),
        .o_rdata (w_fwd_rd)
    );

    scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_rev_ram (
        .i_clk   (i_clk),
        .i_we    (w_mat_we),
        .i_waddr (r_dst),
        .i_wdata (w_rev_wd),
        .i_raddr (w_rev_ra),
        .o_rdata (w_rev_rd)
    );

    assign w_row = r_pass ? (w_rev_rd & {MAX_VERTICES{r_rval[r_top_v]}})
                          : (w_fwd_rd & {MAX_VERTICES{r_fval[r_top_v]}});
    assign w_scan_en = (r_state == scc_pkg::S_SCAN);

    scc_scan #(.N(MAX_VERTICES)) u_scan (
        .i_clk     (i_clk),
        .i_en      (w_scan_en),
        .i_row     (w_row),
        .i_allowed (w_valid & ~r_visited),
        .i_k       (r_top_k),
        .o_res     (w_scan)
    );

    // search stack holds the entries below the top
    assign w_ss_wa = VW'(r_depth - CW'(1));
    assign w_ss_ra = VW'(r_depth - CW'(2));
    assign w_ss_wd = {r_top_v, CW'(w_scan.idx) + CW'(1)};

    scc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_search_ram (
        .i_clk   (i_clk),
        .i_we    (w_ss_we),
        .i_waddr (w_ss_wa),
        .i_wdata (w_ss_wd),
        .i_raddr (w_ss_ra),
        .o_rdata (w_ss_rd)
    );

    assign w_fs_wa = VW'(r_fc);
    assign w_fs_ra = VW'(r_fc - CW'(1));

    scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish_ram (
        .i_clk   (i_clk),
        .i_we    (w_fs_we),
        .i_waddr (w_fs_wa),
        .i_wdata (r_top_v),
        .i_raddr (w_fs_ra),
        .o_rdata (w_fs_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scc_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_in.cmd)
                        scc_pkg::CMD_ADD: begin
                            if (w_edge_ok) begin
                                n_state = scc_pkg::S_EDGE_WR;
                            end
                        end
                        scc_pkg::CMD_RUN: begin
                            n_state = (w_n == '0) ? scc_pkg::S_FLUSH
                                                  : scc_pkg::S_P1_ROOT;
                        end
                        default: n_state = scc_pkg::S_IDLE;
                    endcase
                end
            end
            scc_pkg::S_EDGE_WR: n_state = scc_pkg::S_IDLE;
            scc_pkg::S_P1_ROOT: begin
                if (r_root_cnt == w_n) begin
                    n_state = scc_pkg::S_P2_POP;
                end else if (!r_visited[VW'(r_root_cnt)]) begin
                    n_state = scc_pkg::S_WALK_START;
                end
            end
            scc_pkg::S_WALK_START: begin
                if (!(r_pass && r_pend_valid && !w_can_push)) begin
                    n_state = scc_pkg::S_READ_ROW;
                end
            end
            scc_pkg::S_READ_ROW: n_state = scc_pkg::S_SCAN;
            scc_pkg::S_SCAN:     n_state = scc_pkg::S_PICK;
            scc_pkg::S_PICK: begin
                if (!(r_pass && r_pend_valid && !w_can_push)) begin
                    if (w_scan.found && r_depth < CW'(MAX_VERTICES)) begin
                        n_state = scc_pkg::S_READ_ROW;
                    end else if (r_depth != CW'(1)) begin
                        n_state = scc_pkg::S_POP_WAIT;
                    end else begin
                        n_state = r_pass ? scc_pkg::S_P2_POP : scc_pkg::S_P1_ROOT;
                    end
                end
            end
            scc_pkg::S_POP_WAIT: n_state = scc_pkg::S_READ_ROW;
            scc_pkg::S_P2_POP: begin
                n_state = (r_fc == '0) ? scc_pkg::S_FLUSH : scc_pkg::S_P2_WAIT;
            end
            scc_pkg::S_P2_WAIT: begin
                n_state = r_visited[w_fs_rd] ? scc_pkg::S_P2_POP
                                             : scc_pkg::S_WALK_START;
            end
            scc_pkg::S_FLUSH: begin
                if (w_can_push) begin
                    n_state = scc_pkg::S_IDLE;
                end
            end
            default: n_state = scc_pkg::S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_fval       = r_fval;
        n_rval       = r_rval;
        n_visited    = r_visited;
        n_src        = r_src;
        n_dst        = r_dst;
        n_pass       = r_pass;
        n_root_cnt   = r_root_cnt;
        n_root_v     = r_root_v;
        n_top_v      = r_top_v;
        n_top_k      = r_top_k;
        n_depth      = r_depth;
        n_fc         = r_fc;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        w_move       = 1'b0;
        w_ss_we      = 1'b0;
        w_fs_we      = 1'b0;
        unique case (r_state)
            scc_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_in.cmd)
                        scc_pkg::CMD_CLEAR: begin
                            n_fval = '0;
                            n_rval = '0;
                        end
                        scc_pkg::CMD_ADD: begin
                            n_src = VW'(i_in.src_vertex);
                            n_dst = VW'(i_in.dst_vertex);
                        end
                        scc_pkg::CMD_RUN: begin
                            if (w_n == '0) begin
                                n_pend       = '{vertex_id: '0, component_end: 1'b0,
                                                 last: 1'b1, empty_res: 1'b1};
                                n_pend_valid = 1'b1;
                            end else begin
                                n_visited  = '0;
                                n_fc       = '0;
                                n_root_cnt = '0;
                                n_pass     = 1'b0;
                            end
                        end
                        default: n_pass = r_pass;
                    endcase
                end
            end
            scc_pkg::S_EDGE_WR: begin
                n_fval[r_src] = 1'b1;
                n_rval[r_dst] = 1'b1;
            end
            scc_pkg::S_P1_ROOT: begin
                if (r_root_cnt == w_n) begin
                    n_visited = '0;
                    n_pass    = 1'b1;
                end else if (r_visited[VW'(r_root_cnt)]) begin
                    n_root_cnt = r_root_cnt + CW'(1);
                end else begin
                    n_root_v = VW'(r_root_cnt);
                end
            end
            scc_pkg::S_WALK_START: begin
                if (!(r_pass && r_pend_valid && !w_can_push)) begin
                    n_visited[r_root_v] = 1'b1;
                    n_top_v = r_root_v;
                    n_top_k = '0;
                    n_depth = CW'(1);
                    if (r_pass) begin
                        w_move       = r_pend_valid;
                        n_pend       = '{vertex_id: scc_pkg::VID_W'(r_root_v),
                                         component_end: 1'b0, last: 1'b0,
                                         empty_res: 1'b0};
                        n_pend_valid = 1'b1;
                    end
                end
            end
            scc_pkg::S_PICK: begin
                if (!(r_pass && r_pend_valid && !w_can_push)) begin
                    if (w_scan.found && r_depth < CW'(MAX_VERTICES)) begin
                        // push neighbor, keep resume index below it
                        w_ss_we = 1'b1;
                        n_visited[VW'(w_scan.idx)] = 1'b1;
                        n_top_v = VW'(w_scan.idx);
                        n_top_k = '0;
                        n_depth = r_depth + CW'(1);
                        if (r_pass) begin
                            w_move       = r_pend_valid;
                            n_pend       = '{vertex_id: w_scan.idx, component_end: 1'b0,
                                             last: 1'b0, empty_res: 1'b0};
                            n_pend_valid = 1'b1;
                        end
                    end else begin
                        n_depth = r_depth - CW'(1);
                        if (!r_pass) begin
                            w_fs_we = (r_fc < CW'(MAX_VERTICES));
                            if (r_fc < CW'(MAX_VERTICES)) begin
                                n_fc = r_fc + CW'(1);
                            end
                        end
                        if (r_depth == CW'(1)) begin
                            if (r_pass) begin
                                n_pend.component_end = 1'b1;
                            end else begin
                                n_root_cnt = r_root_cnt + CW'(1);
                            end
                        end
                    end
                end
            end
            scc_pkg::S_POP_WAIT: begin
                n_top_v = w_ss_rd[SW-1:CW];
                n_top_k = w_ss_rd[CW-1:0];
            end
            scc_pkg::S_P2_POP: begin
                if (r_fc == '0) begin
                    n_pend.last = 1'b1;
                end else begin
                    n_fc = r_fc - CW'(1);
                end
            end
            scc_pkg::S_P2_WAIT: begin
                n_root_v = w_fs_rd;
            end
            scc_pkg::S_FLUSH: begin
                if (w_can_push) begin
                    w_move       = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: n_pass = r_pass;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= scc_pkg::S_IDLE;
            r_fval       <= '0;
            r_rval       <= '0;
            r_visited    <= '0;
            r_pass       <= 1'b0;
            r_root_cnt   <= '0;
            r_depth      <= '0;
            r_fc         <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fval       <= n_fval;
            r_rval       <= n_rval;
            r_visited    <= n_visited;
            r_pass       <= n_pass;
            r_root_cnt   <= n_root_cnt;
            r_depth      <= n_depth;
            r_fc         <= n_fc;
            r_pend_valid <= n_pend_valid;
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_root_v <= n_root_v;
        r_top_v  <= n_top_v;
        r_top_k  <= n_top_k;
        r_pend   <= n_pend;
        if (w_move) begin
            r_out <= r_pend;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.vertex_id     = r_out.vertex_id;
    assign o_out.component_end = r_out.component_end;
    assign o_out.last          = r_out.last;
    assign o_out.empty_res     = r_out.empty_res;

    `SCC_ASSERT_NOW(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= CW'(MAX_VERTICES), "search depth past capacity")
    `SCC_ASSERT_NOW(a_flush_pending, i_clk, i_rst_n, r_state == scc_pkg::S_FLUSH, r_pend_valid, "flush without pending result")
    `SCC_ASSERT_NOW(a_idle_drained, i_clk, i_rst_n, i_in.ready, !r_pend_valid, "pending result left at idle")
    `SCC_ASSERT_NEXT(a_empty_run, i_clk, i_rst_n, w_accept && i_in.cmd == scc_pkg::CMD_RUN && w_n == '0, r_pend_valid && r_pend.empty_res && r_pend.last, "empty run without flagged result")

endmodule

`default_nettype wire

// ===== dv/tb_strongly_connected_components.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// SCC block testbench
// Loads directed graphs over the command channel, runs both search passes
// and checks every component transfer against an in-bench component
// predictor, with random bursts, receiver stalls and several vertex counts.
// ------------------------------------------------------------------------
module tb_strongly_connected_components;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int CYCLE_MAX = 2000000;

    typedef struct {
        logic             wr_cfg;
        logic [6:0]       cfg_val;
        logic [1:0]       cmd;
        logic [5:0]       src;
        logic [5:0]       dst;
        int               n_typed;
        scc_pkg::t_result e0;
        scc_pkg::t_result e1;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [scc_pkg::PADDR_W-1:0] paddr = '0;
    logic [scc_pkg::PDATA_W-1:0] pwdata = '0;
    logic [scc_pkg::PDATA_W-1:0] prdata;
    logic pready;

    scc_in_if  in_ch();
    scc_out_if out_ch();

    strongly_connected_components u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0] fwd_rows [64];
    logic [63:0] rev_rows [64];
    logic [63:0] seen;
    logic [5:0]  finish_order [64];
    int          finish_cnt;
    logic [12:0] walk_stack [64];
    int          walk_depth;
    logic [6:0]  vcount_model;

    scc_pkg::t_result component_q [$];
    scc_pkg::t_result typed_rows [int][$];
    t_row    rows [$];
    int      cur_row = -1;
    int      errors = 0;
    int      cycles = 0;
    int      hold_ask = 0, hold_done = 0, hold_cnt = 0;
    int      stall_mode = 0;
    bit      no_gaps = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.src_vertex = '0;
        in_ch.dst_vertex = '0;
        out_ch.ready = 1'b0;
    end

    function automatic void enqueue_result(scc_pkg::t_result res);
        component_q = {component_q, res};
    endfunction

    function automatic int lowest_set(logic [63:0] x);
        for (int i = 0; i < 63; i++) begin
            if (x[i]) return i;
        end
        return 63;
    endfunction

    function automatic void dfs_walk(int root, bit on_rev, logic [63:0] mask, bit emit);
        int top, v, k, j;
        logic [63:0] cand, row;
        seen[root] = 1'b1;
        if (emit) enqueue_result('{vertex_id: root[5:0], default: 1'b0});
        walk_stack[0] = {root[5:0], 7'd0};
        walk_depth = 1;
        while (walk_depth > 0) begin
            top = walk_depth - 1;
            v = walk_stack[top][12:7];
            k = walk_stack[top][6:0];
            cand = '0;
            if (k < 64) begin
                row = on_rev ? rev_rows[v] : fwd_rows[v];
                cand = row & mask & ~seen & ({64{1'b1}} << k);
            end
            if (cand != 0 && walk_depth < 64) begin
                j = lowest_set(cand);
                walk_stack[top] = {v[5:0], 7'(j + 1)};
                seen[j] = 1'b1;
                walk_stack[walk_depth] = {j[5:0], 7'd0};
                walk_depth++;
                if (emit) enqueue_result('{vertex_id: j[5:0], default: 1'b0});
            end else begin
                walk_depth--;
                if (!emit && finish_cnt < 64) begin
                    finish_order[finish_cnt] = v[5:0];
                    finish_cnt++;
                end
            end
        end
    endfunction

    function automatic void scc_predict(logic [1:0] cmd, logic [5:0] s, logic [5:0] d);
        int n, v, start;
        logic [63:0] mask;
        n = vcount_model > 64 ? 64 : vcount_model;
        case (cmd)
            scc_pkg::CMD_CLEAR: begin
                for (int i = 0; i < 64; i++) begin
                    fwd_rows[i] = '0;
                    rev_rows[i] = '0;
                end
            end
            scc_pkg::CMD_ADD: begin
                if (s < n && d < n) begin
                    fwd_rows[s][d] = 1'b1;
                    rev_rows[d][s] = 1'b1;
                end
            end
            scc_pkg::CMD_RUN: begin
                if (n == 0) begin
                    enqueue_result('{vertex_id: '0, component_end: 1'b0,
                                     last: 1'b1, empty_res: 1'b1});
                end else begin
                    mask = (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 1);
                    start = component_q.size();
                    seen = '0;
                    finish_cnt = 0;
                    for (int i = 0; i < n; i++) begin
                        if (!seen[i]) dfs_walk(i, 1'b0, mask, 1'b0);
                    end
                    seen = '0;
                    while (finish_cnt > 0) begin
                        finish_cnt--;
                        v = finish_order[finish_cnt];
                        if (!seen[v]) begin
                            dfs_walk(v, 1'b1, mask, 1'b1);
                            component_q[component_q.size()-1].component_end = 1'b1;
                        end
                    end
                    if (component_q.size() > start)
                        component_q[component_q.size()-1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // accepted commands
    always @(posedge i_clk) begin
        int q_mark;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            q_mark = component_q.size();
            scc_predict(in_ch.cmd, in_ch.src_vertex, in_ch.dst_vertex);
            if (cur_row >= 0 && typed_rows.exists(cur_row)) begin
                while (component_q.size() > q_mark) void'(component_q.pop_back());
                component_q = {component_q, typed_rows[cur_row]};
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        scc_pkg::t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{vertex_id: out_ch.vertex_id, component_end: out_ch.component_end,
                    last: out_ch.last, empty_res: out_ch.empty_res};
            if (component_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %p", $time, got);
                errors++;
            end else begin
                want = component_q.pop_front();
                if (got.empty_res != want.empty_res || got.last != want.last ||
                    got.component_end != want.component_end ||
                    (!want.empty_res && got.vertex_id != want.vertex_id)) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (hold_ask != hold_done) begin
            hold_done <= hold_ask;
            hold_cnt <= 600;
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else begin
            if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 9) < 3);
                default: out_ch.ready <= ((cycles / 5) % 3 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_write(logic [6:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= scc_pkg::ADDR_VCOUNT; pwdata <= scc_pkg::PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        vcount_model = val;
    endtask

    task automatic wait_idle();
        int calm;
        calm = 0;
        while (component_q.size() != 0) @(posedge i_clk);
        while (calm < 20) begin
            @(posedge i_clk);
            calm = in_ch.ready ? calm + 1 : 0;
        end
    endtask

    int burst_left = 0;

    task automatic send_item(int idx, logic [1:0] cmd, logic [5:0] s, logic [5:0] d);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.src_vertex <= s;
        in_ch.dst_vertex <= d;
        cur_row <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void add_row(logic [1:0] cmd, int s, int d);
        rows = {rows, t_row'{wr_cfg: 1'b0, cfg_val: '0, cmd: cmd, src: s[5:0],
                             dst: d[5:0], n_typed: 0, e0: '0, e1: '0}};
    endfunction

    function automatic void add_cfg(int v);
        rows = {rows, t_row'{wr_cfg: 1'b1, cfg_val: v[6:0], cmd: '0, src: '0, dst: '0,
                             n_typed: 0, e0: '0, e1: '0}};
    endfunction

    initial begin
        int n, phase_len, r, s, d;
        logic [1:0] c;
        int vc_pick [10];

        vc_pick = '{0, 1, 2, 3, 5, 16, 33, 64, 100, 127};
        vcount_model = scc_pkg::VCOUNT_RESET;
        for (int i = 0; i < 64; i++) begin
            fwd_rows[i] = '0;
            rev_rows[i] = '0;
        end
        seen = '0;
        finish_cnt = 0;
        walk_depth = 0;

        add_row(scc_pkg::CMD_RUN, 0, 0);
        add_row(scc_pkg::CMD_ADD, 0, 63);
        add_row(scc_pkg::CMD_ADD, 63, 0);
        add_row(scc_pkg::CMD_ADD, 63, 63);
        add_row(scc_pkg::CMD_ADD, 42, 21);
        add_row(CMD_NOP, 63, 63);
        add_row(scc_pkg::CMD_RUN, 0, 0);
        add_cfg(0);
        add_row(scc_pkg::CMD_ADD, 0, 0);
        add_row(scc_pkg::CMD_RUN, 0, 0);
        rows[$].n_typed = 1;
        rows[$].e0 = '{vertex_id: '0, component_end: 1'b0, last: 1'b1, empty_res: 1'b1};
        add_cfg(127);
        add_row(scc_pkg::CMD_RUN, 0, 0);
        add_cfg(2);
        add_row(scc_pkg::CMD_CLEAR, 0, 0);
        add_row(scc_pkg::CMD_ADD, 1, 0);
        add_row(scc_pkg::CMD_ADD, 0, 1);
        add_row(scc_pkg::CMD_ADD, 2, 2);
        add_row(scc_pkg::CMD_ADD, 63, 1);
        add_row(scc_pkg::CMD_RUN, 0, 0);
        rows[$].n_typed = 2;
        rows[$].e0 = '{vertex_id: 6'd0, component_end: 1'b0, last: 1'b0, empty_res: 1'b0};
        rows[$].e1 = '{vertex_id: 6'd1, component_end: 1'b1, last: 1'b1, empty_res: 1'b0};
        add_cfg(64);
        add_row(scc_pkg::CMD_RUN, 0, 0);
        add_row(scc_pkg::CMD_CLEAR, 0, 0);
        add_row(scc_pkg::CMD_RUN, 0, 0);

        foreach (rows[i]) begin
            if (rows[i].n_typed > 1) begin
                typed_rows[i] = {rows[i].e0, rows[i].e1};
            end else if (rows[i].n_typed > 0) begin
                typed_rows[i] = {rows[i].e0};
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].wr_cfg) begin
                drop_valid();
                wait_idle();
                apb_write(rows[i].cfg_val);
            end else begin
                if (i == 6) hold_ask <= hold_ask + 1;
                send_item(i, rows[i].cmd, rows[i].src, rows[i].dst);
            end
        end

        for (int ph = 0; ph < 11; ph++) begin
            drop_valid();
            wait_idle();
            apb_write(ph == 0 ? 7'd64 : 7'(vc_pick[$urandom_range(0, 9)]));
            n = vcount_model > 64 ? 64 : vcount_model;
            no_gaps = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(32, 48);
            if (ph == 3) hold_ask <= hold_ask + 1;
            for (int k = 0; k < phase_len; k++) begin
                r = $urandom_range(0, 99);
                s = $urandom_range(0, 63);
                d = $urandom_range(0, 63);
                if (k == phase_len - 1 || (ph == 3 && k == 0)) c = scc_pkg::CMD_RUN;
                else if (r < 4) c = scc_pkg::CMD_CLEAR;
                else if (r < 8) c = CMD_NOP;
                else if (r < 19) c = scc_pkg::CMD_RUN;
                else begin
                    c = scc_pkg::CMD_ADD;
                    if (n > 0 && $urandom_range(0, 9) != 0) begin
                        s = $urandom_range(0, n - 1);
                        d = (n > 1 && $urandom_range(0, 3) == 0 && s + 1 < n) ?
                            s + 1 : $urandom_range(0, n - 1);
                    end
                end
                send_item(-1, c, s[5:0], d[5:0]);
            end
        end

        drop_valid();
        while (component_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && component_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
